// File: design/wwum_pkg.sv
// Package for the wake window utilization monitor.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package wwum_pkg;

   localparam int ARRIVAL_W  = 40;
   localparam int WINDOW_W   = 32;
   localparam int LIMIT_W    = 5;
   localparam int COUNT_W    = 5;
   localparam int PCT_W      = 7;
   localparam int RSP_DATA_W = 16;
   localparam int SUM_W      = 64;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_WINDOW    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORDS_IN_USE = 1'b1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd100;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
   localparam logic [PCT_W-1:0]    PCT_MAX      = 7'd100;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_CLEAR   = 1'b1;

   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT,
      ST_UPDATE,
      ST_SPAN_RD,
      ST_SPAN,
      ST_SUMS,
      ST_SCALE,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// File: design/wake_window_utilization_monitor.sv
// Top level of the wake window utilization monitor: interval ring in two memories,
// read-modify-write sequencer and a bit-serial percent divider. Uses wwum_pkg.
//
// Usage. The req channel carries one transaction per item: tuser selects an arrival
// or a clear, tdata holds the arrival time in milliseconds. Each item gives exactly
// one rsp transaction with the status in tuser and the interval count and percent
// in tdata. The csr channel writes wake_window (index 0) and records_in_use
// (index 1); it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. An arrival passes the ring lookups with
// registered memory reads and the seven-step restoring divider that forms the percent,
// skipped when the percent is zero or saturates; a clear goes straight to the result.
// No new item is taken until the sequencer is idle; the result is registered on rsp
// as the sequencer leaves its result state. The output register lets a new transaction
// be accepted while the previous result still waits; if the receiver stalls, the
// sequencer holds the next finished result until the output register frees up.
// Reset clears the ring pointers, count and running total and restores the register
// defaults; the memories themselves are not cleared and need no clearing pass.
`default_nettype none

module wake_window_utilization_monitor #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 40
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: arrival_ms[39:0].
   input  wire logic [wwum_pkg::ARRIVAL_W-1:0]      req_tdata,
   // tuser: req_type[0].
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: interval_count[4:0], utilization_pct[11:5], zeros[15:12].
   output logic [wwum_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // tuser: status[0].
   output logic                                     rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [wwum_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wwum_pkg::WINDOW_W-1:0]       csr_data
);

   import wwum_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
   localparam int PRD_W = CNT_W + WINDOW_W;
   localparam int DIV_W = SUM_W + PCT_W;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   logic [IDX_W-1:0]     newest_ff, newest_in;
   logic [CNT_W-1:0]     held_ff, held_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;

   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [TIME_BITS-1:0] gap_ff, gap_in;
   logic                 reject_ff, reject_in;
   logic                 extend_ff, extend_in;
   logic [TIME_BITS-1:0] old_start_ff, old_start_in;
   logic [TIME_BITS-1:0] evict_len_ff, evict_len_in;
   logic [PRD_W-1:0]     prod_ff, prod_in;
   logic [TIME_BITS-1:0] span_ff, span_in;
   logic [SUM_W-1:0]     num_ff, num_in;
   logic [SUM_W-1:0]     den_ff, den_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [PCT_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 status_ff, status_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [PCT_W-1:0]     rsp_pct_ff, rsp_pct_in;

   logic [TIME_BITS-1:0] start_mem [DEPTH];
   logic [TIME_BITS-1:0] end_mem [DEPTH];
   logic [TIME_BITS-1:0] start_rd_ff;
   logic [TIME_BITS-1:0] end_rd_ff;
   logic [IDX_W-1:0]     start_addr;
   logic [IDX_W-1:0]     end_addr;
   logic [IDX_W-1:0]     wr_addr;
   logic                 start_we;
   logic                 end_we;

   logic                 req_accept;
   logic                 rsp_load;
   logic                 pct_zero;
   logic                 pct_sat;
   logic                 div_ge;
   logic [PCT_W-1:0]     quo_next;
   logic [LIM_W-1:0]     limit_eff;
   logic [TIME_BITS:0]   diff;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      ring_next = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_tvalid_ff || rsp_tready);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W - PCT_W){1'b0}}, rsp_pct_ff, rsp_count_ff};

   assign start_addr = oldest_ff;
   assign end_addr   = (state_ff == ST_LOOKUP) ? oldest_ff : newest_ff;

   assign limit_eff = (limit_ff == '0) ? LIM_W'(1) :
                      ((LIM_W'(limit_ff) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(limit_ff));

   assign diff     = {1'b0, t_ff} - {1'b0, end_rd_ff};
   assign pct_zero = (num_ff == '0) || (den_ff == '0);
   assign pct_sat  = DIV_W'(rem_ff) >= (DIV_W'(den_ff) << PCT_W);
   assign div_ge   = DIV_W'(rem_ff) >= div_ff;
   assign quo_next = {quo_ff[PCT_W-2:0], div_ge};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == REQ_CLEAR) ? ST_RESULT : ST_LOOKUP;
            end
         end
         ST_LOOKUP:  state_in = ST_EVICT;
         ST_EVICT:   state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_SPAN_RD;
         ST_SPAN_RD: state_in = ST_SPAN;
         ST_SPAN:    state_in = ST_SUMS;
         ST_SUMS:    state_in = ST_SCALE;
         ST_SCALE: begin
            state_in = (pct_zero || pct_sat) ? ST_RESULT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(PCT_W - 1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic                 evict;
      logic [IDX_W-1:0]     oldest_nx;
      logic [IDX_W-1:0]     newest_nx;
      logic [CNT_W-1:0]     held_mid;

      evict     = LIM_W'(held_ff) >= limit_eff;
      oldest_nx = evict ? ring_next(oldest_ff) : oldest_ff;
      held_mid  = evict ? held_ff - CNT_W'(1) : held_ff;
      newest_nx = (held_mid == '0) ? oldest_nx : ring_next(newest_ff);

      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      held_in      = held_ff;
      total_in     = total_ff;
      window_in    = window_ff;
      limit_in     = limit_ff;
      t_in         = t_ff;
      gap_in       = gap_ff;
      reject_in    = reject_ff;
      extend_in    = extend_ff;
      old_start_in = old_start_ff;
      evict_len_in = evict_len_ff;
      prod_in      = prod_ff;
      span_in      = span_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      status_in    = status_ff;
      pct_in       = pct_ff;
      wr_addr      = newest_ff;
      start_we     = 1'b0;
      end_we       = 1'b0;

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_pct_in    = rsp_pct_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_WAKE_WINDOW:    window_in = csr_data;
            CSR_RECORDS_IN_USE: limit_in  = csr_data[LIMIT_W-1:0];
            default:            window_in = window_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               t_in = TIME_BITS'(req_tdata);
               if (req_tuser == REQ_CLEAR) begin
                  oldest_in = '0;
                  newest_in = '0;
                  held_in   = '0;
                  total_in  = '0;
                  status_in = STATUS_ACCEPTED;
                  pct_in    = '0;
               end
            end
         end
         ST_LOOKUP: begin
            reject_in    = diff[TIME_BITS];
            gap_in       = diff[TIME_BITS-1:0];
            old_start_in = start_rd_ff;
         end
         ST_EVICT: begin
            evict_len_in = end_rd_ff - old_start_ff;
            extend_in    = CMP_W'(gap_ff) <= CMP_W'(window_ff);
         end
         ST_UPDATE: begin
            status_in = STATUS_ACCEPTED;
            if (held_ff == '0) begin
               newest_in = oldest_ff;
               wr_addr   = oldest_ff;
               start_we  = 1'b1;
               end_we    = 1'b1;
               held_in   = CNT_W'(1);
            end else if (reject_ff) begin
               status_in = STATUS_REJECTED;
            end else if (extend_ff) begin
               total_in = total_ff + SUM_W'(gap_ff);
               wr_addr  = newest_ff;
               end_we   = 1'b1;
            end else begin
               total_in  = evict ? total_ff - SUM_W'(evict_len_ff) : total_ff;
               oldest_in = oldest_nx;
               newest_in = newest_nx;
               wr_addr   = newest_nx;
               start_we  = 1'b1;
               end_we    = 1'b1;
               held_in   = held_mid + CNT_W'(1);
            end
         end
         ST_SPAN_RD: begin
            prod_in = PRD_W'(held_ff) * PRD_W'(window_ff);
         end
         ST_SPAN: begin
            span_in = end_rd_ff - start_rd_ff;
            num_in  = total_ff + SUM_W'(prod_ff);
         end
         ST_SUMS: begin
            den_in = SUM_W'(span_ff) + SUM_W'(window_ff);
            // Times one hundred as 64 + 32 + 4.
            rem_in = (num_ff << 6) + (num_ff << 5) + (num_ff << 2);
         end
         ST_SCALE: begin
            div_in  = DIV_W'(den_ff) << (PCT_W - 1);
            quo_in  = '0;
            step_in = '0;
            if (pct_zero) begin
               pct_in = '0;
            end else if (pct_sat) begin
               pct_in = PCT_MAX;
            end
         end
         ST_DIVIDE: begin
            rem_in  = div_ge ? SUM_W'(DIV_W'(rem_ff) - div_ff) : rem_ff;
            quo_in  = quo_next;
            div_in  = div_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            pct_in  = (quo_next > PCT_MAX) ? PCT_MAX : quo_next;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(held_ff);
               rsp_pct_in    = pct_ff;
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[wr_addr] <= t_ff;
      end
      if (end_we) begin
         end_mem[wr_addr] <= t_ff;
      end
      start_rd_ff <= start_mem[start_addr];
      end_rd_ff   <= end_mem[end_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         newest_ff     <= '0;
         held_ff       <= '0;
         total_ff      <= '0;
         window_ff     <= WINDOW_RESET;
         limit_ff      <= LIMIT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         newest_ff     <= newest_in;
         held_ff       <= held_in;
         total_ff      <= total_in;
         window_ff     <= window_in;
         limit_ff      <= limit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      gap_ff        <= gap_in;
      reject_ff     <= reject_in;
      extend_ff     <= extend_in;
      old_start_ff  <= old_start_in;
      evict_len_ff  <= evict_len_in;
      prod_ff       <= prod_in;
      span_ff       <= span_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      pct_ff        <= pct_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_pct_ff    <= rsp_pct_in;
   end

   held_within_depth: assert property (
      @(posedge clock) disable iff (reset) held_ff <= CNT_W'(DEPTH))
      else $error("Interval count exceeds the ring depth.");

   pct_in_range: assert property (
      @(posedge clock) disable iff (reset) rsp_tvalid_ff |-> rsp_pct_ff <= PCT_MAX)
      else $error("Reported percent exceeds one hundred.");

   result_from_sequencer: assert property (
      @(posedge clock) disable iff (reset) $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("Result transaction raised outside the result state.");

   divider_steps_bounded: assert property (
      @(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> step_ff < STEP_W'(PCT_W))
      else $error("Divider ran past its last quotient bit.");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the wake window utilization monitor: a stimulus table,
// then random arrival and clear transactions under several settings, idling and stall patterns.
// Depends on wwum_pkg and wake_window_utilization_monitor only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wwum_pkg::*;

   typedef struct packed {
      logic               status;
      logic [COUNT_W-1:0] count;
      logic [PCT_W-1:0]   pct;
   } usage_report_type;

   typedef struct packed {
      logic                 kind;
      logic [ARRIVAL_W-1:0] stamp;
      logic                 typed;
      usage_report_type     want;
   } directed_row_type;

   localparam logic [ARRIVAL_W-1:0] STAMP_MAX = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ARRIVAL_W-1:0]    req_tdata = '0;
   logic                    req_tuser = REQ_ARRIVAL;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_WAKE_WINDOW;
   logic [WINDOW_W-1:0]     csr_data = '0;

   // Shadow copy of the interval ring and the registers.
   logic [ARRIVAL_W-1:0]    span_start [16];
   logic [ARRIVAL_W-1:0]    span_end [16];
   logic [3:0]              oldest_slot = '0;
   logic [3:0]              newest_slot = '0;
   logic [COUNT_W-1:0]      held = '0;
   logic [SUM_W-1:0]        awake_sum = '0;
   logic [WINDOW_W-1:0]     window_ms = WINDOW_RESET;
   logic [LIMIT_W-1:0]      limit_reg = LIMIT_RESET;

   usage_report_type        pending_reports [$];
   usage_report_type        oldest_report;
   int                      mismatches = 0;
   int                      idle_pct = 0;
   int                      stall_pct = 0;
   int                      hold_left = 0;

   directed_row_type directed_rows [18] = '{
      '{REQ_CLEAR,   40'd0,          1'b1, '{STATUS_ACCEPTED, 5'd0, 7'd0}},
      '{REQ_ARRIVAL, 40'd0,          1'b1, '{STATUS_ACCEPTED, 5'd1, PCT_MAX}},
      '{REQ_ARRIVAL, 40'd50,         1'b0, '0},
      '{REQ_ARRIVAL, 40'd10,         1'b0, '0},
      '{REQ_ARRIVAL, 40'd150,        1'b0, '0},
      '{REQ_ARRIVAL, 40'd251,        1'b0, '0},
      '{REQ_ARRIVAL, 40'd251,        1'b0, '0},
      '{REQ_ARRIVAL, 40'd1000000,    1'b0, '0},
      '{REQ_ARRIVAL, STAMP_MAX,      1'b0, '0},
      '{REQ_ARRIVAL, 40'd0,          1'b0, '0},
      '{REQ_ARRIVAL, STAMP_MAX,      1'b0, '0},
      '{REQ_CLEAR,   STAMP_MAX,      1'b1, '{STATUS_ACCEPTED, 5'd0, 7'd0}},
      '{REQ_ARRIVAL, STAMP_MAX,      1'b1, '{STATUS_ACCEPTED, 5'd1, PCT_MAX}},
      '{REQ_ARRIVAL, 40'hAAAAAAAAAA, 1'b1, '{STATUS_REJECTED, 5'd1, PCT_MAX}},
      '{REQ_CLEAR,   40'h5555555555, 1'b1, '{STATUS_ACCEPTED, 5'd0, 7'd0}},
      '{REQ_ARRIVAL, 40'h5555555555, 1'b1, '{STATUS_ACCEPTED, 5'd1, PCT_MAX}},
      '{REQ_ARRIVAL, 40'hAAAAAAAAAA, 1'b0, '0},
      '{REQ_CLEAR,   40'h0000012345, 1'b1, '{STATUS_ACCEPTED, 5'd0, 7'd0}}
   };

   wake_window_utilization_monitor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PCT_W-1:0] utilisation_now();
      logic [SUM_W-1:0] awake;
      logic [SUM_W-1:0] span;
      logic [SUM_W-1:0] ratio;
      if (held == 0) return '0;
      awake = awake_sum + SUM_W'(held) * SUM_W'(window_ms);
      if (awake == 0) return '0;
      span = SUM_W'(span_end[newest_slot]) + SUM_W'(window_ms) - SUM_W'(span_start[oldest_slot]);
      if (span == 0) return '0;
      ratio = (awake * SUM_W'(100)) / span;
      return (ratio > SUM_W'(PCT_MAX)) ? PCT_MAX : ratio[PCT_W-1:0];
   endfunction

   function automatic usage_report_type advance_monitor(input logic kind,
                                                        input logic [ARRIVAL_W-1:0] stamp);
      usage_report_type   report;
      logic [LIMIT_W-1:0] cap;
      report.status = STATUS_ACCEPTED;
      cap = (limit_reg == 0) ? 5'd1 : ((limit_reg > 5'd16) ? 5'd16 : limit_reg);
      if (kind == REQ_CLEAR) begin
         oldest_slot = '0;
         newest_slot = '0;
         held = '0;
         awake_sum = '0;
      end else if (held != 0 && stamp < span_end[newest_slot]) begin
         report.status = STATUS_REJECTED;
      end else if (held != 0 && SUM_W'(stamp - span_end[newest_slot]) <= SUM_W'(window_ms)) begin
         awake_sum = awake_sum + SUM_W'(stamp - span_end[newest_slot]);
         span_end[newest_slot] = stamp;
      end else begin
         if (held != 0 && held >= cap) begin
            awake_sum = awake_sum - SUM_W'(span_end[oldest_slot] - span_start[oldest_slot]);
            oldest_slot = oldest_slot + 4'd1;
            held = held - 5'd1;
         end
         if (held == 0) newest_slot = oldest_slot;
         else newest_slot = newest_slot + 4'd1;
         span_start[newest_slot] = stamp;
         span_end[newest_slot] = stamp;
         held = held + 5'd1;
      end
      report.count = held;
      report.pct = utilisation_now();
      return report;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < 100)
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("transaction with nothing pending", rsp_tdata, 0);
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_tuser !== oldest_report.status)
               report_mismatch("status", rsp_tuser, oldest_report.status);
            if (rsp_tdata[4:0] !== oldest_report.count)
               report_mismatch("interval_count", rsp_tdata[4:0], oldest_report.count);
            if (rsp_tdata[11:5] !== oldest_report.pct)
               report_mismatch("utilization_pct", rsp_tdata[11:5], oldest_report.pct);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic offer_item(input logic kind, input logic [ARRIVAL_W-1:0] stamp,
                             input logic typed, input usage_report_type typed_report);
      usage_report_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= stamp;
      do @(posedge clock); while (!req_tready);
      predicted = advance_monitor(kind, stamp);
      pending_reports.push_back(typed ? typed_report : predicted);
   endtask

   task automatic pick_random_item(output logic kind, output logic [ARRIVAL_W-1:0] stamp);
      int                   roll;
      logic [SUM_W-1:0]     last;
      logic [SUM_W-1:0]     gap;
      logic [SUM_W-1:0]     offset;
      roll = $urandom_range(99);
      last = SUM_W'(span_end[newest_slot]);
      kind = REQ_ARRIVAL;
      stamp = ARRIVAL_W'({$urandom, $urandom});
      if (roll < 4) begin
         kind = REQ_CLEAR;
      end else if (held == 0) begin
         if ($urandom_range(99) >= 30) stamp = ARRIVAL_W'($urandom);
      end else if (roll < 12) begin
         if (last == 0) begin
            stamp = '0;
         end else begin
            offset = {$urandom, $urandom} % last;
            stamp = ARRIVAL_W'(last - 1 - offset);
         end
      end else begin
         if (roll < 55) gap = SUM_W'($urandom) % (SUM_W'(window_ms) + 1);
         else if (roll < 60) gap = SUM_W'(window_ms);
         else if (roll < 65) gap = SUM_W'(window_ms) + 1;
         else if (roll < 92)
            gap = SUM_W'(window_ms) + 1 + SUM_W'($urandom) % (2 * SUM_W'(window_ms) + 2);
         else gap = SUM_W'($urandom) << $urandom_range(0, 8);
         if (last + gap > SUM_W'(STAMP_MAX)) kind = REQ_CLEAR;
         else stamp = ARRIVAL_W'(last + gap);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WINDOW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WAKE_WINDOW) window_ms = value;
      else limit_reg = value[LIMIT_W-1:0];
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(input logic write_regs, input logic [WINDOW_W-1:0] win,
                            input logic [LIMIT_W-1:0] lim, input int idle, input int stall,
                            input int items, input int hold);
      logic                 kind;
      logic [ARRIVAL_W-1:0] stamp;
      if (write_regs) begin
         write_reg(CSR_WAKE_WINDOW, win);
         write_reg(CSR_RECORDS_IN_USE, {27'($urandom_range(0, 2**27 - 1)), lim});
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      idle_pct = idle;
      stall_pct = stall;
      hold_left = hold;
      repeat (items) begin
         pick_random_item(kind, stamp);
         offer_item(kind, stamp, 1'b0, '0);
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         offer_item(directed_rows[i].kind, directed_rows[i].stamp, directed_rows[i].typed,
                    directed_rows[i].want);
      run_phase(1'b0, WINDOW_RESET, LIMIT_RESET, 0, 0, 300, 0);
      run_phase(1'b1, 32'd0, 5'd1, 79, 0, 200, 0);
      run_phase(1'b1, 32'hFFFFFFFF, 5'd0, 0, 79, 200, 0);
      run_phase(1'b1, WINDOW_W'($urandom_range(1, 5000)), 5'd31, 18, 18, 250, 0);
      run_phase(1'b1, 32'd20, 5'd16, 0, 0, 250, 300);
      run_phase(1'b1, 32'd20, 5'd3, 79, 0, 200, 0);
      run_phase(1'b1, 32'd100000, 5'd16, 0, 79, 150, 0);
      run_phase(1'b1, 32'd1, 5'd8, 18, 18, 150, 0);
      if (pending_reports.size() != 0)
         report_mismatch("results still outstanding", 0, pending_reports.size());
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
